// ===== hdl/bss_pkg.sv =====
// Package for the bounded stack with sort and search.
// Holds operation and status codes, the control word layout and the microcode ROM.
// Used by every module of the block; depends on nothing.
package bss_pkg;

   localparam int DEPTH_DEF = 8;

   // Operation codes of a request.
   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_POP    = 3'd1;
   localparam logic [2:0] OP_SEARCH = 3'd2;
   localparam logic [2:0] OP_SORT   = 3'd3;
   localparam logic [2:0] OP_DUMP   = 3'd4;

   // Status codes of a response.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   // Memory address select.
   localparam logic [1:0] A_J   = 2'd0;
   localparam logic [1:0] A_J1  = 2'd1;
   localparam logic [1:0] A_TOP = 2'd2;
   localparam logic [1:0] A_CNT = 2'd3;

   // Write data select.
   localparam logic [1:0] W_VAL = 2'd0;
   localparam logic [1:0] W_A   = 2'd1;
   localparam logic [1:0] W_B   = 2'd2;

   // Response data select.
   localparam logic [1:0] D_ZERO = 2'd0;
   localparam logic [1:0] D_VAL  = 2'd1;
   localparam logic [1:0] D_RD   = 2'd2;

   // Jump conditions.
   localparam logic [2:0] C_NONE      = 3'd0;
   localparam logic [2:0] C_ALWAYS    = 3'd1;
   localparam logic [2:0] C_EQ        = 3'd2;
   localparam logic [2:0] C_NOT_JLAST = 3'd3;
   localparam logic [2:0] C_PASS_DONE = 3'd4;
   localparam logic [2:0] C_NOT_GT    = 3'd5;
   localparam logic [2:0] C_MORE_PASS = 3'd6;

   localparam int UW = 5;

   // Microcode step addresses.
   localparam logic [UW-1:0] U_END      = 5'd0;
   localparam logic [UW-1:0] U_PUSH     = 5'd1;
   localparam logic [UW-1:0] U_FULL     = 5'd2;
   localparam logic [UW-1:0] U_EMPTY    = 5'd3;
   localparam logic [UW-1:0] U_POP      = 5'd4;
   localparam logic [UW-1:0] U_POP_OUT  = 5'd5;
   localparam logic [UW-1:0] U_SRCH     = 5'd6;
   localparam logic [UW-1:0] U_SRCH_CMP = 5'd7;
   localparam logic [UW-1:0] U_SRCH_NXT = 5'd8;
   localparam logic [UW-1:0] U_NF       = 5'd9;
   localparam logic [UW-1:0] U_FOUND    = 5'd10;
   localparam logic [UW-1:0] U_SORT     = 5'd11;
   localparam logic [UW-1:0] U_SORT_RA  = 5'd12;
   localparam logic [UW-1:0] U_SORT_RB  = 5'd13;
   localparam logic [UW-1:0] U_SORT_CMP = 5'd14;
   localparam logic [UW-1:0] U_SORT_WA  = 5'd15;
   localparam logic [UW-1:0] U_SORT_WB  = 5'd16;
   localparam logic [UW-1:0] U_SORT_INC = 5'd17;
   localparam logic [UW-1:0] U_NPASS    = 5'd18;
   localparam logic [UW-1:0] U_SORT_OUT = 5'd19;
   localparam logic [UW-1:0] U_DUMP     = 5'd20;
   localparam logic [UW-1:0] U_DUMP_OUT = 5'd21;
   localparam logic [UW-1:0] U_DUMP_END = 5'd22;

   typedef struct packed {
      logic          fin;
      logic          emit;
      logic [1:0]    status;
      logic [1:0]    dsel;
      logic          idx_j;
      logic          last_j;
      logic [1:0]    asel;
      logic          we;
      logic [1:0]    wsel;
      logic          load_a;
      logic          load_b;
      logic          cnt_inc;
      logic          cnt_dec;
      logic          j_inc;
      logic          j_clr;
      logic          i_inc;
      logic [2:0]    cond;
      logic [UW-1:0] target;
   } ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic eq;
      logic jlast;
      logic pass_done;
      logic gt;
      logic more_pass;
   } flag_type;

   // First step of the routine for a request.
   function automatic logic [UW-1:0] entry_step(input logic [2:0] op, input logic empty,
                                                input logic full);
      logic [UW-1:0] s;
      s = U_END;
      unique case (op)
         OP_PUSH:   s = full  ? U_FULL  : U_PUSH;
         OP_POP:    s = empty ? U_EMPTY : U_POP;
         OP_SEARCH: s = empty ? U_EMPTY : U_SRCH;
         OP_SORT:   s = empty ? U_EMPTY : U_SORT;
         OP_DUMP:   s = empty ? U_EMPTY : U_DUMP;
         default:   s = U_END;
      endcase
      return s;
   endfunction

   // Microcode ROM.
   function automatic ctrl_type rom_word(input logic [UW-1:0] step);
      ctrl_type w;
      w = '0;
      unique case (step)
         U_PUSH: begin
            w.asel = A_CNT; w.we = 1'b1; w.wsel = W_VAL; w.cnt_inc = 1'b1;
            w.emit = 1'b1; w.status = ST_OK; w.fin = 1'b1;
         end
         U_FULL: begin
            w.emit = 1'b1; w.status = ST_FULL; w.fin = 1'b1;
         end
         U_EMPTY: begin
            w.emit = 1'b1; w.status = ST_EMPTY; w.fin = 1'b1;
         end
         U_POP: begin
            w.asel = A_TOP; w.cnt_dec = 1'b1;
         end
         U_POP_OUT: begin
            w.emit = 1'b1; w.status = ST_OK; w.dsel = D_RD; w.fin = 1'b1;
         end
         U_SRCH: begin
            w.asel = A_J;
         end
         U_SRCH_CMP: begin
            w.cond = C_EQ; w.target = U_FOUND;
         end
         U_SRCH_NXT: begin
            w.j_inc = 1'b1; w.cond = C_NOT_JLAST; w.target = U_SRCH;
         end
         U_NF: begin
            w.emit = 1'b1; w.status = ST_NOTFOUND; w.dsel = D_VAL; w.fin = 1'b1;
         end
         U_FOUND: begin
            w.emit = 1'b1; w.status = ST_OK; w.dsel = D_VAL; w.idx_j = 1'b1;
            w.fin = 1'b1;
         end
         U_SORT: begin
            w.cond = C_PASS_DONE; w.target = U_NPASS;
         end
         U_SORT_RA: begin
            w.asel = A_J;
         end
         U_SORT_RB: begin
            w.load_a = 1'b1; w.asel = A_J1;
         end
         U_SORT_CMP: begin
            w.load_b = 1'b1; w.cond = C_NOT_GT; w.target = U_SORT_INC;
         end
         U_SORT_WA: begin
            w.asel = A_J; w.we = 1'b1; w.wsel = W_B;
         end
         U_SORT_WB: begin
            w.asel = A_J1; w.we = 1'b1; w.wsel = W_A;
         end
         U_SORT_INC: begin
            w.j_inc = 1'b1; w.cond = C_ALWAYS; w.target = U_SORT;
         end
         U_NPASS: begin
            w.i_inc = 1'b1; w.j_clr = 1'b1; w.cond = C_MORE_PASS; w.target = U_SORT;
         end
         U_SORT_OUT: begin
            w.emit = 1'b1; w.status = ST_OK; w.fin = 1'b1;
         end
         U_DUMP: begin
            w.asel = A_J;
         end
         U_DUMP_OUT: begin
            w.emit = 1'b1; w.status = ST_OK; w.dsel = D_RD; w.idx_j = 1'b1;
            w.last_j = 1'b1; w.j_inc = 1'b1; w.cond = C_NOT_JLAST; w.target = U_DUMP;
         end
         default: begin
            w.fin = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/bss_seq.sv =====
// Microcode sequencer: step counter, ROM lookup, dispatch and conditional jumps.
// Depends on bss_pkg.
module bss_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [2:0]        req_op,
   input  bss_pkg::flag_type flags,
   output logic              busy,
   output bss_pkg::ctrl_type ctrl
);
   import bss_pkg::*;

   logic [UW-1:0] upc_ff, upc_in;
   logic          busy_ff, busy_in;
   ctrl_type      word;
   logic          taken;

   assign word = rom_word(upc_ff);
   assign ctrl = busy_ff ? word : '0;
   assign busy = busy_ff;

   always_comb begin
      case (word.cond)
         C_ALWAYS:    taken = 1'b1;
         C_EQ:        taken = flags.eq;
         C_NOT_JLAST: taken = !flags.jlast;
         C_PASS_DONE: taken = flags.pass_done;
         C_NOT_GT:    taken = !flags.gt;
         C_MORE_PASS: taken = flags.more_pass;
         default:     taken = 1'b0;
      endcase
   end

   always_comb begin
      upc_in  = upc_ff;
      busy_in = busy_ff;
      if (!busy_ff) begin
         if (start) begin
            upc_in  = entry_step(req_op, flags.empty, flags.full);
            busy_in = 1'b1;
         end
      end else if (word.fin) begin
         busy_in = 1'b0;
      end else begin
         upc_in = taken ? word.target : upc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff  <= U_END;
         busy_ff <= 1'b0;
      end else begin
         upc_ff  <= upc_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// ===== hdl/bss_dp.sv =====
// Datapath: entry memory, count, loop indices, compare registers and response register.
// Driven by the control word from bss_seq; depends on bss_pkg.
module bss_dp #(
   parameter int DEPTH = bss_pkg::DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic signed [31:0] req_value,
   input  bss_pkg::ctrl_type  ctrl,
   output bss_pkg::flag_type  flags,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_data,
   output logic [2:0]         rsp_index,
   output logic               rsp_last
);
   import bss_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (AW > 3) ? AW : 3;

   logic signed [31:0] mem_ff [DEPTH];
   logic signed [31:0] rd_ff;
   logic signed [31:0] val_ff, a_ff, b_ff;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      j_ff, j_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [AW-1:0]      addr;
   logic signed [31:0] wdata;
   logic [CW:0]        j_p1, i_p1, ji_p1, cnt_x;
   logic [XW-1:0]      j_x;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic signed [31:0] rsp_data_ff;
   logic [2:0]         rsp_index_ff;
   logic               rsp_last_ff;

   assign j_p1  = {1'b0, j_ff} + 1'b1;
   assign i_p1  = {1'b0, i_ff} + 1'b1;
   assign ji_p1 = j_p1 + {1'b0, i_ff};
   assign cnt_x = {1'b0, cnt_ff};
   assign j_x   = XW'(j_ff[AW-1:0]);

   always_comb begin
      case (ctrl.asel)
         A_J:     addr = j_ff[AW-1:0];
         A_J1:    addr = j_p1[AW-1:0];
         A_TOP:   addr = AW'(cnt_ff - 1'b1);
         default: addr = cnt_ff[AW-1:0];
      endcase
   end

   always_comb begin
      case (ctrl.wsel)
         W_A:     wdata = a_ff;
         W_B:     wdata = b_ff;
         default: wdata = val_ff;
      endcase
   end

   assign flags.empty     = (cnt_ff == '0);
   assign flags.full      = (cnt_ff == CW'(DEPTH));
   assign flags.eq        = (rd_ff == val_ff);
   assign flags.jlast     = (j_p1 == cnt_x);
   assign flags.pass_done = (ji_p1 >= cnt_x);
   assign flags.gt        = (a_ff > rd_ff);
   assign flags.more_pass = (i_p1 < cnt_x);

   always_comb begin
      cnt_in = cnt_ff;
      if (ctrl.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (ctrl.cnt_dec) begin
         cnt_in = cnt_ff - 1'b1;
      end
      j_in = j_ff;
      i_in = i_ff;
      if (accept || ctrl.j_clr) begin
         j_in = '0;
      end else if (ctrl.j_inc) begin
         j_in = j_ff + 1'b1;
      end
      if (accept) begin
         i_in = '0;
      end else if (ctrl.i_inc) begin
         i_in = i_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= ctrl.emit;
      end
   end

   // Memory with one address per cycle and registered read data.
   always_ff @(posedge clock) begin
      if (ctrl.we) begin
         mem_ff[addr] <= wdata;
      end
      rd_ff <= mem_ff[addr];
   end

   always_ff @(posedge clock) begin
      j_ff <= j_in;
      i_ff <= i_in;
      if (accept) begin
         val_ff <= req_value;
      end
      if (ctrl.load_a) begin
         a_ff <= rd_ff;
      end
      if (ctrl.load_b) begin
         b_ff <= rd_ff;
      end
      rsp_status_ff <= ctrl.status;
      case (ctrl.dsel)
         D_VAL:   rsp_data_ff <= val_ff;
         D_RD:    rsp_data_ff <= rd_ff;
         default: rsp_data_ff <= '0;
      endcase
      rsp_index_ff <= ctrl.idx_j ? j_x[2:0] : 3'd0;
      rsp_last_ff  <= ctrl.last_j ? flags.jlast : 1'b1;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ===== hdl/bounded_stack_sort_search.sv =====
// Bounded stack with bubble sort and linear search, run by a microcoded sequencer.
// Push, full and empty results come from the step they are sent to; pop reads the
// top entry and then answers; search stops at the first match; dump answers each
// entry in turn, marking the last; sort runs bubble passes of read, compare, swap.
// busy is high while a transaction is at work; the response strobe cannot be stalled.
// Reset clears the count, the sequencer and the strobe; entry memory is not cleared.
module bounded_stack_sort_search #(
   parameter int DEPTH = bss_pkg::DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_op,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_data,
   output logic [2:0]         rsp_index,
   output logic               rsp_last
);
   import bss_pkg::*;

   ctrl_type ctrl;
   flag_type flags;
   logic     accept;

   assign accept = start && !busy;

   bss_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .flags  (flags),
      .busy   (busy),
      .ctrl   (ctrl)
   );

   bss_dp #(.DEPTH(DEPTH)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_value  (req_value),
      .ctrl       (ctrl),
      .flags      (flags),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_index  (rsp_index),
      .rsp_last   (rsp_last)
   );

endmodule

// ===== hdl/bss_chk.sv =====
// Port-level checker for bounded_stack_sort_search, attached by a bind statement.
// Depends on bss_pkg for the status codes.
module bss_chk (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [1:0]         rsp_status,
   input logic signed [31:0] rsp_data,
   input logic [2:0]         rsp_index,
   input logic               rsp_last
);
   import bss_pkg::*;

   // A response only comes out of a transaction that was at work.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a transaction at work");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // Only a dump produces more than one response, and its entries are all ok.
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_last)
      else $error("error response not marked last");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_data == '0 && rsp_index == '0))
      else $error("empty response carries data");

   // A dump that is not finished keeps the block busy.
   a_dump_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> busy)
      else $error("dump stopped before its last entry");

endmodule

bind bounded_stack_sort_search bss_chk u_chk (.*);

// ===== tb/bss_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the bounded stack: watches request and response transactions,
// keeps its own copy of the stack and checks every response in arrival order.
// Depends on bss_pkg for the operation and status codes.
module bss_checker #(
   parameter int DEPTH = bss_pkg::DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [2:0]         req_op,
   input  logic signed [31:0] req_value,
   input  logic               rsp_valid,
   input  logic [1:0]         rsp_status,
   input  logic signed [31:0] rsp_data,
   input  logic [2:0]         rsp_index,
   input  logic               rsp_last,
   output int                 mismatches,
   output int                 pending,
   output int                 replies_checked,
   output int                 full_replies
);
   import bss_pkg::*;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] data;
      logic [2:0]         index;
      logic               last;
   } stack_reply_type;

   logic signed [31:0] held [DEPTH];
   int                 held_count;
   stack_reply_type    replies_due [$];

   function automatic stack_reply_type make_reply(input logic [1:0] status,
                                                  input logic signed [31:0] data,
                                                  input logic [2:0] index,
                                                  input logic last);
      stack_reply_type r;
      r.status = status;
      r.data   = data;
      r.index  = index;
      r.last   = last;
      return r;
   endfunction

   // Applies one request to the local stack copy and queues the replies it causes.
   task automatic apply_stack_op(input logic [2:0] op, input logic signed [31:0] value);
      logic signed [31:0] swap;
      int                 i;
      int                 j;
      bit                 found;
      found = 1'b0;
      if (op > OP_DUMP) begin
         return;
      end
      if (op == OP_PUSH) begin
         if (held_count >= DEPTH) begin
            replies_due.push_back(make_reply(ST_FULL, '0, '0, 1'b1));
         end else begin
            held[held_count] = value;
            held_count++;
            replies_due.push_back(make_reply(ST_OK, '0, '0, 1'b1));
         end
      end else if (held_count == 0) begin
         replies_due.push_back(make_reply(ST_EMPTY, '0, '0, 1'b1));
      end else begin
         case (op)
            OP_POP: begin
               held_count--;
               replies_due.push_back(make_reply(ST_OK, held[held_count], '0, 1'b1));
            end
            OP_SEARCH: begin
               for (i = 0; i < held_count && !found; i++) begin
                  if (held[i] == value) begin
                     found = 1'b1;
                     replies_due.push_back(make_reply(ST_OK, value, 3'(i), 1'b1));
                  end
               end
               if (!found) begin
                  replies_due.push_back(make_reply(ST_NOTFOUND, value, '0, 1'b1));
               end
            end
            OP_SORT: begin
               for (i = 0; i < held_count; i++) begin
                  for (j = 0; j + 1 < held_count - i; j++) begin
                     if (held[j] > held[j + 1]) begin
                        swap = held[j];
                        held[j] = held[j + 1];
                        held[j + 1] = swap;
                     end
                  end
               end
               replies_due.push_back(make_reply(ST_OK, '0, '0, 1'b1));
            end
            default: begin
               for (i = 0; i < held_count; i++) begin
                  replies_due.push_back(make_reply(ST_OK, held[i], 3'(i),
                                                   i + 1 == held_count));
               end
            end
         endcase
      end
   endtask

   always @(posedge clock) begin : watch
      stack_reply_type seen;
      stack_reply_type want;
      if (reset) begin
         held_count = 0;
         replies_due.delete();
         mismatches = 0;
         replies_checked = 0;
         full_replies = 0;
      end else begin
         // A reply at this edge always belongs to an earlier transaction, so it is
         // checked before the request accepted at the same edge is applied.
         if (rsp_valid) begin
            seen = make_reply(rsp_status, rsp_data, rsp_index, rsp_last);
            if (replies_due.size() == 0) begin
               if (mismatches < 10) begin
                  $display("%0t: unexpected reply: status %0d data %0d index %0d last %0b",
                           $time, seen.status, seen.data, seen.index, seen.last);
               end
               mismatches++;
            end else begin
               want = replies_due.pop_front();
               replies_checked++;
               if (want.status == ST_FULL) begin
                  full_replies++;
               end
               if (seen !== want) begin
                  if (mismatches < 10) begin
                     $display("%0t: expected status %0d data %0d index %0d last %0b",
                              $time, want.status, want.data, want.index, want.last);
                     $display("%0t: got      status %0d data %0d index %0d last %0b",
                              $time, seen.status, seen.data, seen.index, seen.last);
                  end
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            apply_stack_op(req_op, req_value);
         end
      end
      pending = replies_due.size();
   end

endmodule

// ===== tb/tb_bounded_stack_sort_search.sv =====
`timescale 1ns / 100ps
// Top of the bounded stack testbench: clock, reset, request stimulus and verdict.
// Depends on bss_pkg, the bounded_stack_sort_search block and the bss_checker scoreboard.
module tb_bounded_stack_sort_search;
   import bss_pkg::*;

   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int GAP_MAX      = 19;
   localparam int RANDOM_ITEMS = 150;
   localparam int DRAIN_CYCLES = 300;
   localparam int STALL_LIMIT  = 2000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_op;
   logic signed [31:0] req_value;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_data;
   logic [2:0]         rsp_index;
   logic               rsp_last;

   int mismatches;
   int pending;
   int replies_checked;
   int full_replies;
   int issued = 0;
   int quiet_cycles = 0;
   bit no_gaps = 1'b0;

   // Small set of words shared by pushes and searches so that searches often hit.
   logic signed [31:0] value_pool [8] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1,
                                          32'sd1, -32'sd2, 32'sh0000_1234, 32'shffff_0000};

   bounded_stack_sort_search #(.DEPTH(DEPTH_DEF)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_data(rsp_data),
      .rsp_index(rsp_index), .rsp_last(rsp_last)
   );

   bss_checker #(.DEPTH(DEPTH_DEF)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_data(rsp_data),
      .rsp_index(rsp_index), .rsp_last(rsp_last),
      .mismatches(mismatches), .pending(pending),
      .replies_checked(replies_checked), .full_replies(full_replies)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("no transaction for %0d cycles, %0d replies outstanding",
                  quiet_cycles, pending);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Called at a rising edge; returns at the edge where the request is taken.
   // busy only moves at rising edges, so sampling it at the falling edge is race free.
   task automatic issue(input logic [2:0] op, input logic signed [31:0] value);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_op    <= op;
      req_value <= value;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      issued++;
   endtask

   // Holds requests off until every outstanding reply has come back.
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic logic [2:0] pick_op(input int push_bias);
      int r;
      r = $urandom_range(0, 99);
      if (r < push_bias) begin
         return OP_PUSH;
      end
      r = $urandom_range(0, 99);
      if (r < 30) return OP_POP;
      if (r < 60) return OP_SEARCH;
      if (r < 75) return OP_SORT;
      if (r < 93) return OP_DUMP;
      return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
   endfunction

   function automatic logic signed [31:0] pick_value();
      if ($urandom_range(0, 1) == 0) begin
         return value_pool[$urandom_range(0, 7)];
      end
      return $urandom;
   endfunction

   initial begin
      int k;
      int n;
      int push_bias;
      reset     = 1'b1;
      start     = 1'b0;
      req_op    = OP_PUSH;
      req_value = '0;
      push_bias = 50;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Pop, search, sort and dump on an empty stack, then the unused codes.
      issue(OP_POP, 32'sd0);
      issue(OP_SEARCH, 32'sh7fff_ffff);
      issue(OP_SORT, 32'sd0);
      issue(OP_DUMP, 32'sd0);
      for (k = OP_SPARE_LO; k <= OP_SPARE_HI; k++) begin
         issue(3'(k), -32'sd1);
      end

      // Fill with the extremes and a duplicate, overflow, then search, sort and dump.
      issue(OP_PUSH, 32'sh7fff_ffff);
      issue(OP_PUSH, 32'sh8000_0000);
      issue(OP_PUSH, 32'sd0);
      issue(OP_PUSH, -32'sd1);
      issue(OP_PUSH, 32'sd1);
      issue(OP_PUSH, -32'sd1);
      issue(OP_PUSH, 32'sh0000_1234);
      issue(OP_PUSH, 32'shffff_0000);
      issue(OP_PUSH, 32'sd5);
      issue(OP_SEARCH, -32'sd1);
      issue(OP_SEARCH, 32'sh5555_5555);
      issue(OP_SEARCH, 32'sh8000_0000);
      issue(OP_SORT, 32'sd0);
      issue(OP_SEARCH, -32'sd1);
      issue(OP_DUMP, 32'sd0);
      issue(OP_POP, 32'sd0);
      issue(OP_POP, 32'sd0);
      drain();

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // New traffic profile every 20 requests: fill-heavy or drain-heavy, gaps or none.
         if (n % 20 == 0) begin
            no_gaps   = ($urandom_range(0, 3) == 0);
            push_bias = $urandom_range(20, 65);
         end
         if (n % 50 == 49) begin
            drain();
         end
         issue(pick_op(push_bias), pick_value());
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests covering every operation, empty and full stack cases;",
               issued);
      $display("%0d replies were checked, %0d of them refusals on a full stack.",
               replies_checked, full_replies);
      if (mismatches == 0 && pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
